[rtl/ihrb_pkg.sv]
// Shared types, codes and helpers for the Intel HEX record blocker.
package ihrb_pkg;

  localparam int CHAR_W   = 8;
  localparam int FILL_W   = 6;
  localparam int ADDR_W   = 32;
  localparam int OUT_DW   = 80;
  localparam int KIND_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOF    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_SYNTAX   = 2'd1;
  localparam logic [1:0] ERR_CHECKSUM = 2'd2;
  localparam logic [1:0] ERR_TYPE     = 2'd3;

  // record types
  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_EXTLA = 8'h04;
  localparam logic [7:0] REC_START = 8'h05;

  // configuration register indexes
  localparam logic CFG_ADDR_SHIFT  = 1'b0;
  localparam logic CFG_BLOCK_LIMIT = 1'b1;

  localparam logic [FILL_W-1:0] BLOCK_LIMIT_RST = 6'd56;
  localparam logic [FILL_W-1:0] BLOCK_LIMIT_MIN = 6'd2;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN,
    PH_ADDRH,
    PH_ADDRL,
    PH_TYPE,
    PH_DATA,
    PH_CHK
  } phase_t;

  // classified input word
  typedef struct packed {
    logic       restart;
    logic       colon;
    logic       is_hex;
    logic [3:0] nib;
  } token_t;

  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

[rtl/ihrb_front.sv]
// Front end: classifies each incoming character word into a parser token.
module ihrb_front import ihrb_pkg::*; (
  input  logic              act,
  input  logic [CHAR_W-1:0] char_code,
  output token_t            tok
);

  logic [4:0] dec;

  always_comb begin
    dec         = hex_decode(char_code);
    tok.restart = act;
    tok.colon   = (char_code == CHAR_COLON);
    tok.is_hex  = ~dec[4];
    tok.nib     = dec[3:0];
  end

endmodule

[rtl/ihrb_fifo.sv]
// Short token queue between the front end and the record parser.
module ihrb_fifo import ihrb_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t din,
  output logic   full,
  input  logic   pop,
  output token_t dout,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  token_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= din;
  end

endmodule

[rtl/ihrb_back.sv]
// Back end: record parser, block tracking and the output register.
module ihrb_back import ihrb_pkg::*; #(
  parameter int MAX_BLOCK = 56
) (
  input  logic               clk,
  input  logic               rst_n,
  input  token_t             tok,
  input  logic               tok_avail,
  output logic               tok_pop,
  input  logic [1:0]         addr_shift,
  input  logic [FILL_W-1:0]  block_limit,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_DW-1:0]  out_tdata,
  output logic [KIND_W-1:0]  out_tuser
);

  localparam logic [FILL_W-1:0] MAX_LIM = FILL_W'(MAX_BLOCK);

  phase_t             phase_r, phase_nxt;
  logic [3:0]         high_r, high_nxt;
  logic               pend_r, pend_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         left_r, left_nxt;
  logic [15:0]        alow_r, alow_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [15:0]        upper_r, upper_nxt;
  logic [15:0]        shadow_r, shadow_nxt;
  logic [ADDR_W-1:0]  naddr_r, naddr_nxt;
  logic [ADDR_W-1:0]  bstart_r, bstart_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               halted_r, halted_nxt;

  logic               oval_r, oval_nxt;
  logic [KIND_W-1:0]  okind_r;
  logic [7:0]         obyte_r;
  logic [ADDR_W-1:0]  oaddr_r;
  logic               osb_r;
  logic [ADDR_W-1:0]  obda_r;
  logic [1:0]         oerr_r;

  logic               emit;
  logic [KIND_W-1:0]  r_kind;
  logic [7:0]         r_byte;
  logic [ADDR_W-1:0]  r_addr;
  logic               r_sb;
  logic [ADDR_W-1:0]  r_bda;
  logic [1:0]         r_err;

  logic [7:0]         byte_val, sum_inc, idx, left_dec;
  logic [FILL_W-1:0]  lim, fill_tmp;
  logic [ADDR_W-1:0]  target, addr_inc, naddr_tmp;

  assign tok_pop = tok_avail && (!oval_r || out_tready);

  always_comb begin
    lim = block_limit;
    if (lim < BLOCK_LIMIT_MIN) lim = BLOCK_LIMIT_MIN;
    if (lim > MAX_LIM) lim = MAX_LIM;
  end

  always_comb begin
    phase_nxt  = phase_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    alow_nxt   = alow_r;
    type_nxt   = type_r;
    sum_nxt    = sum_r;
    upper_nxt  = upper_r;
    shadow_nxt = shadow_r;
    naddr_nxt  = naddr_r;
    bstart_nxt = bstart_r;
    fill_nxt   = fill_r;
    halted_nxt = halted_r;

    emit   = 1'b0;
    r_kind = KIND_DATA;
    r_byte = '0;
    r_addr = '0;
    r_sb   = 1'b0;
    r_bda  = '0;
    r_err  = ERR_OK;

    byte_val  = {high_r, tok.nib};
    sum_inc   = sum_r + byte_val;
    idx       = len_r - left_r;
    left_dec  = left_r - 8'd1;
    target    = {upper_r, alow_r};
    addr_inc  = naddr_r + 32'd1;
    fill_tmp  = fill_r + 1'b1;
    naddr_tmp = addr_inc;

    if (tok_pop) begin
      priority if (tok.restart) begin
        phase_nxt  = PH_WAIT;
        high_nxt   = '0;
        pend_nxt   = 1'b0;
        len_nxt    = '0;
        left_nxt   = '0;
        alow_nxt   = '0;
        type_nxt   = '0;
        sum_nxt    = '0;
        upper_nxt  = '0;
        shadow_nxt = '0;
        naddr_nxt  = '0;
        bstart_nxt = '0;
        fill_nxt   = '0;
        halted_nxt = 1'b0;
      end else if (halted_r) begin
        // drop everything until restart
      end else if (phase_r == PH_WAIT) begin
        if (tok.colon) begin
          phase_nxt  = PH_LEN;
          pend_nxt   = 1'b0;
          sum_nxt    = '0;
          shadow_nxt = '0;
        end
      end else if (!tok.is_hex) begin
        halted_nxt = 1'b1;
        phase_nxt  = PH_WAIT;
        emit       = 1'b1;
        r_kind     = KIND_ERROR;
        r_err      = ERR_SYNTAX;
      end else if (!pend_r) begin
        high_nxt = tok.nib;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        sum_nxt  = sum_inc;
        unique case (phase_r)
          PH_LEN: begin
            len_nxt   = byte_val;
            left_nxt  = byte_val;
            phase_nxt = PH_ADDRH;
          end
          PH_ADDRH: begin
            alow_nxt  = {byte_val, 8'h00};
            phase_nxt = PH_ADDRL;
          end
          PH_ADDRL: begin
            alow_nxt  = {alow_r[15:8], byte_val};
            phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt = byte_val;
            // discontiguous data record opens a new block
            if (byte_val == REC_DATA && target != naddr_r) begin
              naddr_nxt  = target;
              bstart_nxt = target;
              fill_nxt   = '0;
            end
            phase_nxt = (left_r != '0) ? PH_DATA : PH_CHK;
          end
          PH_DATA: begin
            left_nxt = left_dec;
            if (left_dec == '0) phase_nxt = PH_CHK;
            if (type_r == REC_DATA) begin
              emit   = 1'b1;
              r_kind = KIND_DATA;
              r_byte = byte_val;
              r_addr = naddr_r;
              r_sb   = (fill_r == '0);
              r_bda  = bstart_r >> addr_shift;
              if (fill_tmp >= lim) fill_tmp = '0;
              if (naddr_r == '1) begin
                naddr_tmp = '0;
                fill_tmp  = '0;
              end
              naddr_nxt = naddr_tmp;
              fill_nxt  = fill_tmp;
              if (fill_tmp == '0) bstart_nxt = naddr_tmp;
            end else if (type_r == REC_EXTLA && idx < 8'd2) begin
              shadow_nxt = {shadow_r[7:0], byte_val};
            end
          end
          PH_CHK: begin
            phase_nxt = PH_WAIT;
            emit      = 1'b1;
            priority if (sum_inc != '0) begin
              halted_nxt = 1'b1;
              r_kind     = KIND_ERROR;
              r_err      = ERR_CHECKSUM;
            end else if (type_r == REC_DATA || type_r == REC_START) begin
              r_kind = KIND_ACCEPT;
            end else if (type_r == REC_EOF) begin
              r_kind = KIND_EOF;
            end else if (type_r == REC_EXTLA) begin
              if (len_r < 8'd2) begin
                halted_nxt = 1'b1;
                r_kind     = KIND_ERROR;
                r_err      = ERR_SYNTAX;
              end else begin
                upper_nxt  = shadow_r;
                naddr_nxt  = {shadow_r, 16'h0000};
                bstart_nxt = {shadow_r, 16'h0000};
                fill_nxt   = '0;
                r_kind     = KIND_ACCEPT;
              end
            end else begin
              halted_nxt = 1'b1;
              r_kind     = KIND_ERROR;
              r_err      = ERR_TYPE;
            end
          end
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end

    // hold a stalled word, load a fresh one behind a taken one
    if (tok_pop && emit) oval_nxt = 1'b1;
    else if (out_tready) oval_nxt = 1'b0;
    else oval_nxt = oval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      high_r   <= '0;
      pend_r   <= 1'b0;
      len_r    <= '0;
      left_r   <= '0;
      alow_r   <= '0;
      type_r   <= '0;
      sum_r    <= '0;
      upper_r  <= '0;
      shadow_r <= '0;
      naddr_r  <= '0;
      bstart_r <= '0;
      fill_r   <= '0;
      halted_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      alow_r   <= alow_nxt;
      type_r   <= type_nxt;
      sum_r    <= sum_nxt;
      upper_r  <= upper_nxt;
      shadow_r <= shadow_nxt;
      naddr_r  <= naddr_nxt;
      bstart_r <= bstart_nxt;
      fill_r   <= fill_nxt;
      halted_r <= halted_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      okind_r <= r_kind;
      obyte_r <= r_byte;
      oaddr_r <= r_addr;
      osb_r   <= r_sb;
      obda_r  <= r_bda;
      oerr_r  <= r_err;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {5'b0, oerr_r, obda_r, osb_r, oaddr_r, obyte_r};

endmodule

[rtl/intel_hex_record_blocker_core.sv]
// Intel HEX record blocker: top level with configuration registers.
//
// Input stream: one word per character. in_tuser is the restart flag
// (clears all parser state, gives no result); in_tdata is the ASCII code.
// Output stream: at most one word per input word. out_tuser is the kind
// (data byte, record accepted, end of file, error); out_tdata carries the
// data byte, its 32-bit byte address, the starts-block flag, the block's
// device address and the error code.
// Data bytes are sent before the checksum is seen: commit a record only on
// an accepted verdict. After an error the block drops characters until a
// restart word.
// Throughput: one character per cycle while in_tready is high. An accepted
// word waits in the token queue; its result is then registered and shown on out_tvalid.
// When out_tready stays low the output register holds its word, the token
// queue fills and in_tready falls once FIFO_DEPTH tokens wait.
// Reset clears the parser, the queue, addr_shift (0) and block_limit (56).
// Configuration: APB, addr_shift at 0x0, block_limit at 0x4; write only
// while the block is idle.
module intel_hex_record_blocker_core import ihrb_pkg::*; #(
  parameter int MAX_BLOCK  = 56,
  parameter int FIFO_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // char_code[7:0]
  input  logic              in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  // data_byte[7:0], byte_addr[39:8], starts_block[40], block_dev_addr[72:41],
  // error_code[74:73], zero[79:75]
  output logic [OUT_DW-1:0] out_tdata,
  output logic [KIND_W-1:0] out_tuser,  // kind
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [1:0]        addr_shift_r, addr_shift_nxt;
  logic [FILL_W-1:0] block_limit_r, block_limit_nxt;
  logic              cfg_wr;

  token_t            tok_in, tok_out;
  logic              q_full, q_empty, q_pop, q_push;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    addr_shift_nxt  = addr_shift_r;
    block_limit_nxt = block_limit_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_ADDR_SHIFT:  addr_shift_nxt  = cfg_pwdata[1:0];
        CFG_BLOCK_LIMIT: block_limit_nxt = cfg_pwdata[FILL_W-1:0];
        default: ;
      endcase
    end
    unique case (cfg_paddr[2])
      CFG_ADDR_SHIFT:  cfg_prdata = {30'b0, addr_shift_r};
      CFG_BLOCK_LIMIT: cfg_prdata = {26'b0, block_limit_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_shift_r  <= '0;
      block_limit_r <= BLOCK_LIMIT_RST;
    end else begin
      addr_shift_r  <= addr_shift_nxt;
      block_limit_r <= block_limit_nxt;
    end
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid && in_tready;

  ihrb_front u_front (
    .act       (in_tuser),
    .char_code (in_tdata),
    .tok       (tok_in)
  );

  ihrb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (tok_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (tok_out),
    .empty (q_empty)
  );

  ihrb_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok         (tok_out),
    .tok_avail   (~q_empty),
    .tok_pop     (q_pop),
    .addr_shift  (addr_shift_r),
    .block_limit (block_limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

[tb/intel_hex_record_blocker_checker.sv]
// Checker for the Intel HEX record blocker: predicts every result word and compares.
module intel_hex_record_blocker_checker import ihrb_pkg::*; #(
  parameter int MAX_BLOCK = 56
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [KIND_W-1:0] out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  input  logic              end_check,
  output int                failures,
  output int                pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] addr;
    logic        opens;
    logic [31:0] dev_addr;
    logic [1:0]  err;
  } hex_result_t;

  hex_result_t awaited_results [$];
  hex_result_t oldest;
  int          fail_total = 0;
  int          results_seen = 0;

  // register copies
  logic [1:0]  shift_cfg;
  logic [5:0]  limit_cfg;

  // parser copy
  phase_t      ph;
  logic [3:0]  hi_nib;
  logic        nib_wait;
  logic [7:0]  rec_len;
  logic [7:0]  left;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [7:0]  csum;
  logic [15:0] upper;
  logic [15:0] upper_shadow;
  logic [31:0] next_addr;
  logic [31:0] blk_start;
  logic [5:0]  blk_fill;
  logic        halted;

  task automatic report(input string msg);
    if (fail_total < 40) $display("MISMATCH %s", msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s is %0h, predicted %0h", results_seen, name, got, want));
  endtask

  task automatic clear_parser();
    ph = PH_WAIT;
    hi_nib = '0;
    nib_wait = 1'b0;
    rec_len = '0;
    left = '0;
    rec_addr = '0;
    rec_type = '0;
    csum = '0;
    upper = '0;
    upper_shadow = '0;
    next_addr = '0;
    blk_start = '0;
    blk_fill = '0;
    halted = 1'b0;
  endtask

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] value,
                              input logic [31:0] addr, input logic opens,
                              input logic [31:0] dev_addr, input logic [1:0] err);
    hex_result_t r;
    r.kind = kind;
    r.value = value;
    r.addr = addr;
    r.opens = opens;
    r.dev_addr = dev_addr;
    r.err = err;
    awaited_results.push_back(r);
  endtask

  task automatic fail_record(input logic [1:0] code);
    halted = 1'b1;
    ph = PH_WAIT;
    queue_result(KIND_ERROR, '0, '0, 1'b0, '0, code);
  endtask

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  task automatic decode_char(input logic restart, input logic [7:0] ch);
    int          digit;
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [31:0] target;
    logic [5:0]  lim;
    if (restart) begin
      clear_parser();
      return;
    end
    if (halted) return;
    if (ph == PH_WAIT) begin
      if (ch == CHAR_COLON) begin
        ph = PH_LEN;
        nib_wait = 1'b0;
        csum = '0;
        upper_shadow = '0;
      end
      return;
    end
    digit = hex_value(ch);
    if (digit < 0) begin
      fail_record(ERR_SYNTAX);
      return;
    end
    if (!nib_wait) begin
      hi_nib = digit[3:0];
      nib_wait = 1'b1;
      return;
    end
    nib_wait = 1'b0;
    b = {hi_nib, digit[3:0]};
    csum = csum + b;
    case (ph)
      PH_LEN: begin
        rec_len = b;
        left = b;
        ph = PH_ADDRH;
      end
      PH_ADDRH: begin
        rec_addr = {b, 8'h00};
        ph = PH_ADDRL;
      end
      PH_ADDRL: begin
        rec_addr[7:0] = b;
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        rec_type = b;
        if (b == REC_DATA) begin
          target = {upper, rec_addr};
          // a jump in address opens a new block, even for an empty record
          if (target != next_addr) begin
            next_addr = target;
            blk_start = target;
            blk_fill = '0;
          end
        end
        ph = (left != 0) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        idx = rec_len - left;
        left = left - 8'd1;
        if (left == 0) ph = PH_CHK;
        if (rec_type == REC_DATA) begin
          queue_result(KIND_DATA, b, next_addr, blk_fill == 0, blk_start >> shift_cfg, ERR_OK);
          lim = limit_cfg;
          if (lim < BLOCK_LIMIT_MIN) lim = BLOCK_LIMIT_MIN;
          if (lim > MAX_BLOCK) lim = 6'(MAX_BLOCK);
          blk_fill++;
          if (blk_fill >= lim) blk_fill = '0;
          // wrap to zero always opens a new block
          if (next_addr == '1) begin
            next_addr = '0;
            blk_fill = '0;
          end else begin
            next_addr++;
          end
          if (blk_fill == 0) blk_start = next_addr;
        end else if (rec_type == REC_EXTLA && idx < 2) begin
          upper_shadow = {upper_shadow[7:0], b};
        end
      end
      PH_CHK: begin
        ph = PH_WAIT;
        if (csum != 0) begin
          fail_record(ERR_CHECKSUM);
        end else if (rec_type == REC_DATA || rec_type == REC_START) begin
          queue_result(KIND_ACCEPT, '0, '0, 1'b0, '0, ERR_OK);
        end else if (rec_type == REC_EOF) begin
          queue_result(KIND_EOF, '0, '0, 1'b0, '0, ERR_OK);
        end else if (rec_type == REC_EXTLA) begin
          if (rec_len < 2) begin
            fail_record(ERR_SYNTAX);
          end else begin
            upper = upper_shadow;
            next_addr = {upper_shadow, 16'h0000};
            blk_start = next_addr;
            blk_fill = '0;
            queue_result(KIND_ACCEPT, '0, '0, 1'b0, '0, ERR_OK);
          end
        end else begin
          fail_record(ERR_TYPE);
        end
      end
      default: ph = PH_WAIT;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      shift_cfg = '0;
      limit_cfg = BLOCK_LIMIT_RST;
      awaited_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == CFG_BLOCK_LIMIT) limit_cfg = cfg_pwdata[5:0];
        else shift_cfg = cfg_pwdata[1:0];
      end
      if (in_tvalid && in_tready) decode_char(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report($sformatf("result %0d: word of kind %0d arrived with none awaited",
                           results_seen, out_tuser));
        end else begin
          oldest = awaited_results.pop_front();
          // out_tdata: data_byte, byte_addr, starts_block, block_dev_addr, error_code
          check_field("kind", 32'(out_tuser), 32'(oldest.kind));
          check_field("data_byte", 32'(out_tdata[7:0]), 32'(oldest.value));
          check_field("byte_addr", out_tdata[39:8], oldest.addr);
          check_field("starts_block", 32'(out_tdata[40]), 32'(oldest.opens));
          check_field("block_dev_addr", out_tdata[72:41], oldest.dev_addr);
          check_field("error_code", 32'(out_tdata[74:73]), 32'(oldest.err));
        end
      end
      if (end_check && awaited_results.size() != 0) begin
        report($sformatf("%0d awaited words never arrived", awaited_results.size()));
        awaited_results.delete();
      end
    end
    failures <= fail_total;
    pending <= awaited_results.size();
  end

endmodule

[tb/intel_hex_record_blocker_core_tb.sv]
// Testbench top for the Intel HEX record blocker: stimulus, idling and verdict.
module intel_hex_record_blocker_core_tb import ihrb_pkg::*; ;

  localparam int MAX_BLOCK   = 56;
  localparam int ITEM_TARGET = 1450;
  localparam int SEGMENTS    = 8;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  logic              end_check = 1'b0;
  int                failure_count;
  int                results_pending;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          holds_wanted = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          words_sent = 0;
  int          cycles = 0;
  logic [15:0] cursor = '0;
  logic [7:0]  payload [256];

  intel_hex_record_blocker_core #(.MAX_BLOCK(MAX_BLOCK)) dut (.*);

  intel_hex_record_blocker_checker #(.MAX_BLOCK(MAX_BLOCK)) u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .end_check, .failures(failure_count), .pending(results_pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_wanted) begin
      out_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
    end else begin
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  task automatic send_word(input logic action, input logic [7:0] ch);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // hold the input until every predicted word is out and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // send one record from payload; at cut_at swap in a bad char or a restart and stop
  task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] rtype, input logic bad_sum,
                             input int cut_at, input logic cut_action);
    logic [7:0] frame [$];
    logic [7:0] sum;
    logic [7:0] junk;
    int         k;
    frame = {len, addr[15:8], addr[7:0], rtype};
    for (k = 0; k < len; k++) frame.push_back(payload[k]);
    sum = '0;
    for (k = 0; k < frame.size(); k++) sum = sum + frame[k];
    sum = -sum;
    if (bad_sum) sum = sum ^ (8'h01 << $urandom_range(7));
    frame.push_back(sum);
    send_word(1'b0, CHAR_COLON);
    for (k = 0; k < 2 * frame.size(); k++) begin
      if (k == cut_at) begin
        if (cut_action) begin
          send_word(1'b1, 8'($urandom));
        end else begin
          junk = CHAR_COLON;
          if ($urandom_range(9) > 2) begin
            do junk = 8'($urandom); while (is_hex(junk));
          end
          send_word(1'b0, junk);
        end
        return;
      end
      send_word(1'b0, hex_char(k[0] ? frame[k / 2][3:0] : frame[k / 2][7:4],
                               1'($urandom_range(1))));
    end
  endtask

  // feed a few characters into the halted block, then restart it
  task automatic recover();
    int n;
    n = $urandom_range(3);
    repeat (n) send_word(1'b0, 8'($urandom));
    send_word(1'b1, 8'($urandom));
    cursor = '0;
  endtask

  task automatic send_noise();
    logic [7:0] c;
    int         n;
    n = 1 + $urandom_range(2);
    repeat (n) begin
      case ($urandom_range(2))
        0: c = 8'h0d;
        1: c = 8'h0a;
        default: do c = 8'($urandom); while (c == CHAR_COLON);
      endcase
      send_word(1'b0, c);
    end
  endtask

  task automatic random_record();
    int          pick;
    int          r;
    int          k;
    int          cut_at;
    logic        cut_action;
    logic        bad_sum;
    logic        halts;
    logic [7:0]  len;
    logic [7:0]  rtype;
    logic [15:0] addr;
    pick = $urandom_range(99);
    bad_sum = ($urandom_range(99) < 3);
    cut_at = -1;
    cut_action = 1'b0;
    addr = 16'($urandom);
    for (k = 0; k < 256; k++) payload[k] = 8'($urandom);
    if (pick < 60) begin
      rtype = REC_DATA;
      len = ($urandom_range(59) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
      if ($urandom_range(3) != 0) addr = cursor;
      else if ($urandom_range(5) == 0) addr = 16'hfff0 | 16'($urandom_range(15));
    end else if (pick < 72) begin
      rtype = REC_EXTLA;
      r = $urandom_range(9);
      len = (r == 0) ? 8'($urandom_range(1)) : (r == 1) ? 8'(3 + $urandom_range(3)) : 8'd2;
      if ($urandom_range(3) == 0) begin
        payload[0] = 8'hff;
        payload[1] = 8'hff;
      end
    end else if (pick < 77) begin
      rtype = REC_START;
      len = 8'($urandom_range(4));
    end else if (pick < 83) begin
      rtype = REC_EOF;
      len = 8'($urandom_range(2));
    end else if (pick < 88) begin
      do rtype = 8'($urandom);
      while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_EXTLA || rtype == REC_START);
      len = 8'($urandom_range(3));
    end else begin
      rtype = REC_DATA;
      len = 8'($urandom_range(6));
      addr = cursor;
      cut_at = $urandom_range(2 * len + 9);
      cut_action = 1'($urandom_range(1));
    end
    send_record(len, addr, rtype, bad_sum, cut_at, cut_action);
    if (cut_at >= 0) begin
      halts = !cut_action;
    end else begin
      halts = bad_sum || (rtype == REC_EXTLA && len < 2) ||
              !(rtype == REC_DATA || rtype == REC_EOF || rtype == REC_EXTLA ||
                rtype == REC_START);
    end
    if (halts) begin
      recover();
    end else begin
      if (cut_at >= 0) cursor = '0;
      else if (rtype == REC_DATA) cursor = addr + 16'(len);
      else if (rtype == REC_EXTLA)
        cursor = (payload[0] == 8'hff && payload[1] == 8'hff) ? 16'hfffa : 16'h0000;
      if ($urandom_range(49) == 0) begin
        send_word(1'b1, 8'($urandom));
        cursor = '0;
      end
      if ($urandom_range(2) == 0) send_noise();
    end
  endtask

  initial begin
    int seg;
    int seg_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short directed pass at reset settings
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hff);
    send_word(1'b1, 8'hff);
    send_record(8'd0, 16'h0000, REC_EOF, 1'b0, -1, 1'b0);
    payload[0] = 8'h00;
    payload[1] = 8'hff;
    payload[2] = 8'h7e;
    send_record(8'd3, 16'h0010, REC_DATA, 1'b0, -1, 1'b0);
    send_noise();
    send_record(8'd2, 16'h0013, REC_DATA, 1'b0, -1, 1'b0);
    send_record(8'd0, 16'h1000, REC_DATA, 1'b0, -1, 1'b0);
    send_record(8'd1, 16'h1000, REC_DATA, 1'b0, -1, 1'b0);
    send_record(8'd4, 16'h2222, REC_START, 1'b0, -1, 1'b0);
    payload[0] = 8'hff;
    payload[1] = 8'hff;
    send_record(8'd2, 16'h0000, REC_EXTLA, 1'b0, -1, 1'b0);
    payload[0] = 8'hc3;
    payload[1] = 8'h3c;
    payload[2] = 8'h5a;
    payload[3] = 8'ha5;
    send_record(8'd4, 16'hfffe, REC_DATA, 1'b0, -1, 1'b0);
    payload[0] = 8'h00;
    payload[1] = 8'h01;
    payload[2] = 8'haa;
    send_record(8'd3, 16'h0000, REC_EXTLA, 1'b0, -1, 1'b0);
    send_record(8'd1, 16'h0000, REC_EXTLA, 1'b0, -1, 1'b0);
    recover();
    send_record(8'd1, 16'h0040, REC_DATA, 1'b1, -1, 1'b0);
    recover();
    send_record(8'd0, 16'h0000, 8'h02, 1'b0, -1, 1'b0);
    recover();
    send_record(8'd0, 16'h0000, 8'h03, 1'b0, -1, 1'b0);
    recover();
    send_record(8'd2, 16'h0050, REC_DATA, 1'b0, 6, 1'b0);
    recover();
    send_record(8'd2, 16'h0050, REC_DATA, 1'b0, 9, 1'b1);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        0: begin write_reg(CFG_ADDR_SHIFT, 32'd1); write_reg(CFG_BLOCK_LIMIT, 32'd2); end
        1: begin write_reg(CFG_ADDR_SHIFT, 32'd2); write_reg(CFG_BLOCK_LIMIT, 32'd5); end
        2: begin write_reg(CFG_ADDR_SHIFT, 32'd3); write_reg(CFG_BLOCK_LIMIT, 32'd63); end
        3: begin write_reg(CFG_ADDR_SHIFT, 32'd0); write_reg(CFG_BLOCK_LIMIT, 32'd0); end
        4: begin write_reg(CFG_ADDR_SHIFT, 32'd2); write_reg(CFG_BLOCK_LIMIT, 32'd1); end
        5: begin write_reg(CFG_ADDR_SHIFT, 32'd0); write_reg(CFG_BLOCK_LIMIT, 32'd56); end
        6: begin write_reg(CFG_ADDR_SHIFT, 32'd1); write_reg(CFG_BLOCK_LIMIT, 32'd17); end
        default: begin
          write_reg(CFG_ADDR_SHIFT, $urandom_range(3));
          write_reg(CFG_BLOCK_LIMIT, $urandom_range(63));
        end
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 75; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 75; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      // back up the output while the input keeps streaming
      if (seg == 4) holds_wanted++;
      // spread what is left of the word budget over the remaining segments
      seg_end = words_sent + (ITEM_TARGET - words_sent) / (SEGMENTS - seg);
      while (words_sent < seg_end) random_record();
    end

    drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (failure_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
